/* sv/imtt_pkg.sv */
// ----------------------------------------------------------------------------
// imtt_pkg
// shared widths, operation and status codes, and types of the ip to mac
// translation table
// ----------------------------------------------------------------------------
package imtt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int MODE_W   = 2;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_FOUND   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd4;

    // access to the ip and mac stores, both share one address pair
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } tbl_acc_t;

    // table index to the reported slot, low bits kept
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

/* sv/imtt_ifs.sv */
// ----------------------------------------------------------------------------
// imtt channel interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface imtt_req_if;
    logic                          valid;
    logic                          ready;
    logic [imtt_pkg::MODE_W-1:0]   mode;
    logic [imtt_pkg::IP_W-1:0]     ip_addr;
    logic [imtt_pkg::MAC_W-1:0]    mac_addr;

    modport source (output valid, output mode, output ip_addr, output mac_addr,
                    input ready);
    modport sink   (input valid, input mode, input ip_addr, input mac_addr,
                    output ready);
endinterface

interface imtt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [imtt_pkg::STATUS_W-1:0] status;
    logic [imtt_pkg::MAC_W-1:0]    mac_out;
    logic [imtt_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, output status, output mac_out, output slot,
                    input ready);
    modport sink   (input valid, input status, input mac_out, input slot,
                    output ready);
endinterface

/* sv/ip_to_mac_translation_table.sv */
// ----------------------------------------------------------------------------
// ip_to_mac_translation_table
// ipv4 to mac table with lookup, add to lowest free slot, delete and clear
// ----------------------------------------------------------------------------
//  channel  dir  payload                         transaction
//  req      in   mode, ip_addr, mac_addr         one operation
//  rsp      out  status, mac_out, slot           one result per operation
//
//  a scan reads one entry per cycle from the ip and mac rams (one registered
//  read port each) and stops at the first matching valid entry; a miss or
//  an add of a new ip scans all TABLE_ENTRIES slots, clear all skips the scan
//  one operation is in work at a time; req is taken only while idle
//  valid marks sit in flops cleared by reset; no clearing pass is needed
//  a stalled rsp holds one result while the next req is already accepted
// ----------------------------------------------------------------------------
module ip_to_mac_translation_table (
    input  logic        clk,
    input  logic        rst_n,
    imtt_req_if.sink    req,
    imtt_rsp_if.source  rsp
);

    imtt_pkg::tbl_acc_t                acc;
    logic [imtt_pkg::IP_W-1:0]         wr_ip;
    logic [imtt_pkg::MAC_W-1:0]        wr_mac;
    logic [imtt_pkg::IP_W-1:0]         rd_ip;
    logic [imtt_pkg::MAC_W-1:0]        rd_mac;

    imtt_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .acc    (acc),
        .wr_ip  (wr_ip),
        .wr_mac (wr_mac),
        .rd_ip  (rd_ip),
        .rd_mac (rd_mac)
    );

    imtt_ram #(
        .WIDTH (imtt_pkg::IP_W),
        .DEPTH (imtt_pkg::TABLE_ENTRIES)
    ) u_ip_ram (
        .clk     (clk),
        .wr_en   (acc.wr_en),
        .wr_addr (acc.wr_addr),
        .wr_data (wr_ip),
        .rd_en   (acc.rd_en),
        .rd_addr (acc.rd_addr),
        .rd_data (rd_ip)
    );

    imtt_ram #(
        .WIDTH (imtt_pkg::MAC_W),
        .DEPTH (imtt_pkg::TABLE_ENTRIES)
    ) u_mac_ram (
        .clk     (clk),
        .wr_en   (acc.wr_en),
        .wr_addr (acc.wr_addr),
        .wr_data (wr_mac),
        .rd_en   (acc.rd_en),
        .rd_addr (acc.rd_addr),
        .rd_data (rd_mac)
    );

endmodule

/* sv/imtt_ram.sv */
// ----------------------------------------------------------------------------
// imtt_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module imtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/imtt_engine.sv */
// ----------------------------------------------------------------------------
// imtt_engine
// valid marks, sequential scan of the ip store and result register
// ----------------------------------------------------------------------------
module imtt_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    imtt_req_if.sink                     req,
    imtt_rsp_if.source                   rsp,
    output imtt_pkg::tbl_acc_t           acc,
    output logic [imtt_pkg::IP_W-1:0]    wr_ip,
    output logic [imtt_pkg::MAC_W-1:0]   wr_mac,
    input  logic [imtt_pkg::IP_W-1:0]    rd_ip,
    input  logic [imtt_pkg::MAC_W-1:0]   rd_mac
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [imtt_pkg::IDX_W-1:0] LAST_IDX =
        imtt_pkg::IDX_W'(imtt_pkg::TABLE_ENTRIES - 1);
    localparam logic [imtt_pkg::CNT_W-1:0] CNT_END =
        imtt_pkg::CNT_W'(imtt_pkg::TABLE_ENTRIES);

    // control state
    logic [1:0]                          state_reg, state_next;
    logic [imtt_pkg::TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic [imtt_pkg::CNT_W-1:0]          iss_cnt_reg, iss_cnt_next;
    logic                                cmp_vld_reg, cmp_vld_next;
    logic                                hit_reg, hit_next;
    logic                                free_vld_reg, free_vld_next;
    logic                                out_vld_reg, out_vld_next;

    // payload
    logic [imtt_pkg::IDX_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [imtt_pkg::IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [imtt_pkg::IDX_W-1:0]          free_idx_reg, free_idx_next;
    logic [imtt_pkg::MAC_W-1:0]          hit_mac_reg, hit_mac_next;
    logic [imtt_pkg::MODE_W-1:0]         mode_reg, mode_next;
    logic [imtt_pkg::IP_W-1:0]           ip_reg, ip_next;
    logic [imtt_pkg::MAC_W-1:0]          mac_in_reg, mac_in_next;
    logic [imtt_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [imtt_pkg::MAC_W-1:0]          mac_out_reg, mac_out_next;
    logic [imtt_pkg::SLOT_W-1:0]         slot_reg, slot_next;

    logic                                rd_en;
    logic                                hit_now;
    logic                                cmp_free;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        iss_cnt_next  = iss_cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_mac_next  = hit_mac_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        mode_next     = mode_reg;
        ip_next       = ip_reg;
        mac_in_next   = mac_in_reg;
        status_next   = status_reg;
        mac_out_next  = mac_out_reg;
        slot_next     = slot_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;

        rd_en       = (state_reg == S_SCAN) && (iss_cnt_reg < CNT_END);
        acc.rd_en   = rd_en;
        acc.rd_addr = iss_cnt_reg[imtt_pkg::IDX_W-1:0];
        acc.wr_en   = 1'b0;
        acc.wr_addr = free_idx_reg;
        wr_ip       = ip_reg;
        wr_mac      = mac_in_reg;

        // read data of the previous cycle belongs to cmp_idx_reg
        hit_now  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_ip == ip_reg);
        cmp_free = cmp_vld_reg && !valid_reg[cmp_idx_reg];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next     = req.mode;
                    ip_next       = req.ip_addr;
                    mac_in_next   = req.mac_addr;
                    iss_cnt_next  = '0;
                    hit_next      = 1'b0;
                    free_vld_next = 1'b0;
                    state_next    = (req.mode == imtt_pkg::MODE_CLEAR) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    iss_cnt_next = iss_cnt_reg + imtt_pkg::CNT_W'(1);
                end
                cmp_vld_next = rd_en;
                cmp_idx_next = acc.rd_addr;
                // first free slot seen so far, for an add that misses
                if (cmp_free && !free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
                priority if (hit_now)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_mac_next = rd_mac;
                    state_next   = S_DONE;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next = 1'b1;
                    status_next  = imtt_pkg::STAT_MISS;
                    mac_out_next = '0;
                    slot_next    = '0;
                    state_next   = S_IDLE;
                    priority if (mode_reg == imtt_pkg::MODE_CLEAR)
                    begin
                        status_next = imtt_pkg::STAT_CLEARED;
                        valid_next  = '0;
                    end
                    else if (hit_reg)
                    begin
                        status_next  = imtt_pkg::STAT_FOUND;
                        mac_out_next = hit_mac_reg;
                        slot_next    = imtt_pkg::to_slot(hit_idx_reg);
                        if (mode_reg == imtt_pkg::MODE_DELETE)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                    end
                    else if (mode_reg == imtt_pkg::MODE_ADD)
                    begin
                        if (free_vld_reg)
                        begin
                            status_next              = imtt_pkg::STAT_ADDED;
                            mac_out_next             = mac_in_reg;
                            slot_next                = imtt_pkg::to_slot(free_idx_reg);
                            valid_next[free_idx_reg] = 1'b1;
                            acc.wr_en                = 1'b1;
                        end
                        else
                        begin
                            status_next = imtt_pkg::STAT_FULL;
                        end
                    end
                    else
                    begin
                        // lookup or delete that found nothing
                        status_next = imtt_pkg::STAT_MISS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            iss_cnt_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            iss_cnt_reg  <= iss_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            hit_reg      <= hit_next;
            free_vld_reg <= free_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_mac_reg  <= hit_mac_next;
        mode_reg     <= mode_next;
        ip_reg       <= ip_next;
        mac_in_reg   <= mac_in_next;
        status_reg   <= status_next;
        mac_out_reg  <= mac_out_next;
        slot_reg     <= slot_next;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_vld_reg;
    assign rsp.status  = status_reg;
    assign rsp.mac_out = mac_out_reg;
    assign rsp.slot    = slot_reg;

endmodule

/* sv/imtt_checker.sv */
// ----------------------------------------------------------------------------
// imtt_checker
// port level checks of the translation table, bound to the top level
// ----------------------------------------------------------------------------
module imtt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [imtt_pkg::STATUS_W-1:0] status,
    input logic [imtt_pkg::MAC_W-1:0]    mac_out,
    input logic [imtt_pkg::SLOT_W-1:0]   slot
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(mac_out) && $stable(slot))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status <= imtt_pkg::STAT_CLEARED)
        else $error("status code out of range");

    // only found and added carry a mac and slot
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != imtt_pkg::STAT_FOUND && status != imtt_pkg::STAT_ADDED
            |-> mac_out == '0 && slot == '0)
        else $error("miss, full or clear result with nonzero mac or slot");

    // every operation keeps the block busy, so ready is low in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous transaction in work");

endmodule

bind ip_to_mac_translation_table imtt_checker u_imtt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .mac_out   (rsp.mac_out),
    .slot      (rsp.slot)
);
